// ----- hdl/mbrs_pkg.sv -----
package mbrs_pkg;

  localparam int unsigned SlotsDefault     = 4;
  localparam int unsigned AddrWordsDefault = 1024;
  localparam int unsigned MaxReadDefault   = 125;
  localparam int unsigned MaxWriteDefault  = 123;
  localparam int unsigned RegSlots         = 4;
  localparam int unsigned MaxSlave         = 247;
  localparam int unsigned CfgIdxW          = 2;
  localparam int unsigned CfgDataW         = 8;

  localparam logic [1:0] ModeHeader  = 2'd0;
  localparam logic [1:0] ModePayload = 2'd1;
  localparam logic [1:0] ModeLoad    = 2'd2;

  localparam logic [7:0] FcReadHolding = 8'd3;
  localparam logic [7:0] FcReadInput   = 8'd4;
  localparam logic [7:0] FcWriteSingle = 8'd6;
  localparam logic [7:0] FcWriteMulti  = 8'd16;

  localparam logic [1:0] StNormal  = 2'd0;
  localparam logic [1:0] StIllFunc = 2'd1;
  localparam logic [1:0] StIllAddr = 2'd2;
  localparam logic [1:0] StIllVal  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] reg_address;
    logic [15:0] quantity;
    logic [7:0]  byte_count;
    logic [7:0]  data_size;
    logic [15:0] word_value;
    logic        load_table;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  echo_function;
    logic [7:0]  resp_byte_count;
    logic [15:0] word_first;
    logic [15:0] word_second;
    logic        last;
  } rsp_t;

endpackage

// ----- hdl/mbrs_table.sv -----
module mbrs_table #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic [AW-1:0] clr_addr_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          map_we_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o,
  output logic          rmap_o
);
  logic [15:0] words_q [DEPTH];
  logic [15:0] words_rd_q;
  logic        map_q   [DEPTH];
  logic        map_rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      words_q[waddr_i] <= wdata_i;
    end
    words_rd_q <= words_q[raddr_i];
    rdata_o <= words_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      map_q[clr_addr_i] <= 1'b0;
    end else if (map_we_i) begin
      map_q[waddr_i] <= 1'b1;
    end
    map_rd_q <= map_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmap_o <= 1'b0;
    end else begin
      rmap_o <= map_rd_q;
    end
  end
endmodule

// ----- hdl/modbus_register_server.sv -----
// Modbus holding and input register server for several slaves.
// Items enter on start/req_i when busy is low; results leave on
// rsp_o with rsp_valid_o high for one cycle each, and cannot be held off.
// Configuration writes on cfg_we_i set the slave served by each slot.
// Tables live in one memory per table, read one entry per cycle through
// a registered read port. A load or a payload word that does not complete
// a write is taken while busy stays low. A header with a bad value or
// function answers in the cycle after acceptance; one for an unserved slave
// gets no answer. A read checks each register's mapped bit in S_SCAN and
// S_SWAIT, then reads in S_RD, S_RW1 and S_RW2, one result per two registers.
// A single write checks its mapped bit the same way, then writes and answers.
// A write-multiple header scans its range in the same way; if it passed, the
// final payload word copies the buffer into the holding table via S_COPY and
// S_CWAIT and answers from S_DONE, else it answers with the exception.
// After reset the mapped bits are cleared by a pass over all
// SLOTS*ADDR_WORDS entries, during which busy stays high.
module modbus_register_server #(
  parameter int unsigned SLOTS      = mbrs_pkg::SlotsDefault,
  parameter int unsigned ADDR_WORDS = mbrs_pkg::AddrWordsDefault,
  parameter int unsigned MAX_READ   = mbrs_pkg::MaxReadDefault,
  parameter int unsigned MAX_WRITE  = mbrs_pkg::MaxWriteDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mbrs_pkg::req_t      req_i,
  output logic                rsp_valid_o,
  output mbrs_pkg::rsp_t      rsp_o,
  input  logic                cfg_we_i,
  input  logic [mbrs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbrs_pkg::CfgDataW-1:0] cfg_data_i
);
  import mbrs_pkg::*;

  localparam int unsigned DEPTH = SLOTS * ADDR_WORDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WAW   = (ADDR_WORDS > 1) ? $clog2(ADDR_WORDS) : 1;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_SWAIT = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_RW1   = 4'd5;
  localparam logic [3:0] S_RW2   = 4'd6;
  localparam logic [3:0] S_COPY  = 4'd7;
  localparam logic [3:0] S_CWAIT = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [7:0]  slot_q [RegSlots];
  logic [AW:0] cnt_q, cnt_d;
  logic [16:0] idx_q, idx_d;
  logic        bad_q, bad_d;
  req_t        hdr_q, hdr_d;
  logic [SW-1:0] cslot_q, cslot_d;
  logic [15:0] w1_q, w1_d;

  logic [6:0]  prem_q, prem_d, pqty_q, pqty_d;
  logic [15:0] pstart_q, pstart_d;
  logic [1:0]  perr_q, perr_d;
  logic [SW-1:0] pslot_q, pslot_d;
  logic [15:0] pbuf_q [128];
  logic [15:0] pbuf_rd_q;
  logic        pb_we;
  logic [6:0]  pb_waddr, pb_raddr;

  logic        rv_d;
  rsp_t        r_d;

  logic [7:0]  nslave;
  logic        hit;
  logic [SW-1:0] hslot;

  logic        h_we, h_mwe, i_we, i_mwe, clr;
  logic [AW-1:0] waddr, raddr;
  logic [15:0] wdata, h_rd, i_rd;
  logic        h_map, i_map;

  always_comb begin
    nslave = (req_i.slave_address == 8'd0 || req_i.slave_address > 8'(MaxSlave))
             ? 8'd1 : req_i.slave_address;
    hit = 1'b0;
    hslot = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (k < RegSlots && slot_q[k] != 8'd0 && slot_q[k] == nslave) begin
        hit = 1'b1;
        hslot = SW'(k);
      end
    end
  end

  function automatic logic [AW-1:0] ent(input logic [SW-1:0] s, input logic [16:0] a);
    logic [AW+16:0] e;
    e = (AW+17)'(s) * (AW+17)'(ADDR_WORDS) + (AW+17)'(a);
    return e[AW-1:0];
  endfunction

  mbrs_table #(.DEPTH(DEPTH), .AW(AW)) u_hold (
    .clk_i, .rst_ni, .clr_i(clr), .clr_addr_i(cnt_q[AW-1:0]),
    .we_i(h_we), .waddr_i(waddr), .wdata_i(wdata), .map_we_i(h_mwe),
    .raddr_i(raddr), .rdata_o(h_rd), .rmap_o(h_map)
  );
  mbrs_table #(.DEPTH(DEPTH), .AW(AW)) u_inp (
    .clk_i, .rst_ni, .clr_i(clr), .clr_addr_i(cnt_q[AW-1:0]),
    .we_i(i_we), .waddr_i(waddr), .wdata_i(wdata), .map_we_i(i_mwe),
    .raddr_i(raddr), .rdata_o(i_rd), .rmap_o(i_map)
  );

  always_ff @(posedge clk_i) begin
    if (pb_we) begin
      pbuf_q[pb_waddr] <= req_i.word_value;
    end
    pbuf_rd_q <= pbuf_q[pb_raddr];
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    logic cur_map, is_rd;
    logic [15:0] cur_w;
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; bad_d = bad_q;
    hdr_d = hdr_q; cslot_d = cslot_q; w1_d = w1_q;
    prem_d = prem_q; pqty_d = pqty_q; pstart_d = pstart_q;
    perr_d = perr_q; pslot_d = pslot_q;
    rv_d = 1'b0; r_d = '0;
    clr = 1'b0; h_we = 1'b0; h_mwe = 1'b0; i_we = 1'b0; i_mwe = 1'b0;
    waddr = '0; raddr = '0; wdata = req_i.word_value;
    pb_we = 1'b0; pb_waddr = pqty_q - prem_q; pb_raddr = cnt_q[6:0];
    is_rd = (hdr_q.function_code == FcReadInput);
    cur_map = is_rd ? i_map : h_map;
    cur_w = is_rd ? i_rd : h_rd;
    case (state_q)
      S_CLR: begin
        clr = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          hdr_d = req_i;
          cslot_d = hslot;
          case (req_i.mode)
            ModeLoad: begin
              waddr = ent(hslot, {1'b0, req_i.reg_address});
              if (hit && 32'(req_i.reg_address) < ADDR_WORDS) begin
                if (req_i.load_table) begin
                  i_we = 1'b1; i_mwe = 1'b1;
                end else begin
                  h_we = 1'b1; h_mwe = 1'b1;
                end
              end
            end
            ModePayload: begin
              if (prem_q != 7'd0) begin
                pb_we = 1'b1;
                prem_d = prem_q - 1'b1;
                if (prem_q == 7'd1) begin
                  if (perr_q != StNormal) begin
                    rv_d = 1'b1;
                    r_d.status = perr_q;
                    r_d.echo_function = FcWriteMulti;
                    r_d.last = 1'b1;
                  end else begin
                    cnt_d = '0;
                    state_d = S_COPY;
                  end
                end
              end
            end
            ModeHeader: begin
              prem_d = '0;
              if (hit) begin
                rv_d = 1'b1;
                r_d.echo_function = req_i.function_code;
                r_d.last = 1'b1;
                case (req_i.function_code)
                  FcReadHolding, FcReadInput: begin
                    if (req_i.data_size != 8'd4 || req_i.quantity == 16'd0 ||
                        32'(req_i.quantity) > MAX_READ) begin
                      r_d.status = StIllVal;
                    end else begin
                      rv_d = 1'b0;
                      idx_d = '0; bad_d = 1'b0;
                      state_d = S_SCAN;
                    end
                  end
                  FcWriteSingle: begin
                    if (req_i.data_size != 8'd4) begin
                      r_d.status = StIllVal;
                    end else begin
                      rv_d = 1'b0;
                      idx_d = '0; bad_d = 1'b0;
                      state_d = S_SCAN;
                    end
                  end
                  FcWriteMulti: begin
                    if (req_i.data_size < 8'd5 || req_i.quantity == 16'd0 ||
                        32'(req_i.quantity) > MAX_WRITE ||
                        req_i.byte_count != 8'({req_i.quantity, 1'b0}) ||
                        9'(req_i.data_size) != 9'(req_i.byte_count) + 9'd5) begin
                      r_d.status = StIllVal;
                    end else begin
                      rv_d = 1'b0;
                      idx_d = '0; bad_d = 1'b0;
                      state_d = S_SCAN;
                    end
                  end
                  default: begin
                    r_d.status = StIllFunc;
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        raddr = ent(cslot_q, 17'(hdr_q.reg_address) + idx_q);
        if (32'(hdr_q.reg_address) + 32'(idx_q) >= ADDR_WORDS) begin
          bad_d = 1'b1;
        end
        cnt_d = '0;
        state_d = S_SWAIT;
      end
      S_SWAIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(1)) begin
          if (!cur_map) begin
            bad_d = 1'b1;
          end
          idx_d = idx_q + 1'b1;
          state_d = S_SCAN;
          if (bad_d || idx_q + 17'd1 >= 17'(hdr_q.function_code == FcWriteSingle
                                             ? 16'd1 : hdr_q.quantity)) begin
            state_d = S_IDLE;
            r_d.echo_function = hdr_q.function_code;
            r_d.last = 1'b1;
            if (hdr_q.function_code == FcWriteMulti) begin
              perr_d = bad_d ? StIllAddr : StNormal;
              pstart_d = hdr_q.reg_address;
              pqty_d = hdr_q.quantity[6:0];
              prem_d = hdr_q.quantity[6:0];
              pslot_d = cslot_q;
            end else if (bad_d) begin
              rv_d = 1'b1;
              r_d.status = StIllAddr;
            end else if (hdr_q.function_code == FcWriteSingle) begin
              rv_d = 1'b1;
              h_we = 1'b1;
              waddr = ent(cslot_q, {1'b0, hdr_q.reg_address});
              wdata = hdr_q.quantity;
              r_d.word_first = hdr_q.reg_address;
              r_d.word_second = hdr_q.quantity;
            end else begin
              idx_d = '0;
              state_d = S_RD;
            end
          end
        end
      end
      S_RD: begin
        raddr = ent(cslot_q, 17'(hdr_q.reg_address) + idx_q);
        cnt_d = '0;
        state_d = S_RW1;
      end
      S_RW1: begin
        cnt_d = cnt_q + 1'b1;
        raddr = ent(cslot_q, 17'(hdr_q.reg_address) + idx_q + 17'd1);
        if (cnt_q == (AW+1)'(1)) begin
          w1_d = cur_w;
          cnt_d = '0;
          state_d = S_RW2;
        end
      end
      S_RW2: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (AW+1)'(1)) begin
          rv_d = 1'b1;
          r_d.echo_function = hdr_q.function_code;
          r_d.resp_byte_count = 8'({hdr_q.quantity, 1'b0});
          r_d.word_first = w1_q;
          r_d.word_second = (idx_q + 17'd1 < 17'(hdr_q.quantity)) ? cur_w : 16'd0;
          r_d.last = (idx_q + 17'd2 >= 17'(hdr_q.quantity));
          idx_d = idx_q + 17'd2;
          state_d = r_d.last ? S_IDLE : S_RD;
        end
      end
      S_COPY: begin
        pb_raddr = cnt_q[6:0];
        state_d = S_CWAIT;
      end
      S_CWAIT: begin
        h_we = 1'b1;
        waddr = ent(pslot_q, 17'(pstart_q) + 17'(cnt_q[6:0]));
        wdata = pbuf_rd_q;
        cnt_d = cnt_q + 1'b1;
        state_d = (cnt_q[6:0] + 7'd1 == pqty_q) ? S_DONE : S_COPY;
      end
      S_DONE: begin
        rv_d = 1'b1;
        r_d.echo_function = FcWriteMulti;
        r_d.word_first = pstart_q;
        r_d.word_second = 16'(pqty_q);
        r_d.last = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      cnt_q <= '0;
      idx_q <= '0;
      bad_q <= 1'b0;
      prem_q <= '0;
      pqty_q <= '0;
      pstart_q <= '0;
      perr_q <= '0;
      pslot_q <= '0;
      rsp_valid_o <= 1'b0;
      for (int k = 0; k < RegSlots; k++) begin
        slot_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      bad_q <= bad_d;
      prem_q <= prem_d;
      pqty_q <= pqty_d;
      pstart_q <= pstart_d;
      perr_q <= perr_d;
      pslot_q <= pslot_d;
      rsp_valid_o <= rv_d;
      if (cfg_we_i) begin
        slot_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    cslot_q <= cslot_d;
    w1_q <= w1_d;
    rsp_o <= r_d;
  end
endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import mbrs_pkg::*;

  localparam int unsigned NSlots   = SlotsDefault;
  localparam int unsigned NWords   = AddrWordsDefault;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  modbus_register_server dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the server state.
  logic [15:0] hold_mem[NSlots*NWords];
  logic [15:0] in_mem[NSlots*NWords];
  bit hold_map[NSlots*NWords];
  bit in_map[NSlots*NWords];
  logic [15:0] wr_buf[128];
  int unsigned wr_left, wr_base, wr_cnt, wr_slot;
  logic [1:0] wr_err;
  logic [7:0] slave_of_slot[RegSlots];

  rsp_t answers_due[$];
  int n_items, n_answers, n_fail, idle_cycles;
  bit burst;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int slot_of(logic [7:0] sa);
    logic [7:0] s;
    s = (sa == 8'd0 || sa > MaxSlave) ? 8'd1 : sa;
    for (int k = 0; k < NSlots && k < RegSlots; k++) begin
      if (slave_of_slot[k] != 8'd0 && slave_of_slot[k] == s) return k;
    end
    return -1;
  endfunction

  function automatic bit span_mapped(bit inp, int s, int unsigned a, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (a + i >= NWords) return 1'b0;
      if (inp ? !in_map[s*NWords+a+i] : !hold_map[s*NWords+a+i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_answer(logic [1:0] st, logic [7:0] fc, logic [7:0] bc,
                                      logic [15:0] w1, logic [15:0] w2, logic lst);
    rsp_t a;
    a.status = st; a.echo_function = fc; a.resp_byte_count = bc;
    a.word_first = w1; a.word_second = w2; a.last = lst;
    answers_due.push_back(a);
  endfunction

  function automatic void predict_answers(req_t r);
    int s;
    int unsigned a, q, e;
    logic [7:0] fc;
    s = slot_of(r.slave_address);
    a = r.reg_address;
    q = r.quantity;
    fc = r.function_code;
    if (r.mode == ModeLoad) begin
      if (s >= 0 && a < NWords) begin
        e = s * NWords + a;
        if (r.load_table) begin in_map[e] = 1'b1; in_mem[e] = r.word_value; end
        else begin hold_map[e] = 1'b1; hold_mem[e] = r.word_value; end
      end
    end else if (r.mode == ModePayload) begin
      if (wr_left != 0) begin
        wr_buf[(wr_cnt - wr_left) & 127] = r.word_value;
        wr_left--;
        if (wr_left == 0) begin
          if (wr_err != StNormal) begin
            push_answer(wr_err, FcWriteMulti, 8'd0, 16'd0, 16'd0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < wr_cnt; i++)
              hold_mem[wr_slot*NWords+wr_base+i] = wr_buf[i & 127];
            push_answer(StNormal, FcWriteMulti, 8'd0, wr_base[15:0], wr_cnt[15:0], 1'b1);
          end
        end
      end
    end else if (r.mode == ModeHeader) begin
      wr_left = 0;
      if (s >= 0) begin
        if (fc == FcReadHolding || fc == FcReadInput) begin
          if (r.data_size != 8'd4 || q == 0 || q > MaxReadDefault) begin
            push_answer(StIllVal, fc, 8'd0, 16'd0, 16'd0, 1'b1);
          end else if (!span_mapped(fc == FcReadInput, s, a, q)) begin
            push_answer(StIllAddr, fc, 8'd0, 16'd0, 16'd0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < q; i += 2) begin
              e = s * NWords + a + i;
              push_answer(StNormal, fc, 8'(q * 2),
                          fc == FcReadInput ? in_mem[e] : hold_mem[e],
                          i + 1 < q ? (fc == FcReadInput ? in_mem[e+1] : hold_mem[e+1]) : 16'd0,
                          i + 2 >= q);
            end
          end
        end else if (fc == FcWriteSingle) begin
          if (r.data_size != 8'd4) begin
            push_answer(StIllVal, fc, 8'd0, 16'd0, 16'd0, 1'b1);
          end else if (!span_mapped(1'b0, s, a, 1)) begin
            push_answer(StIllAddr, fc, 8'd0, 16'd0, 16'd0, 1'b1);
          end else begin
            hold_mem[s*NWords+a] = r.quantity;
            push_answer(StNormal, fc, 8'd0, r.reg_address, r.quantity, 1'b1);
          end
        end else if (fc == FcWriteMulti) begin
          if (r.data_size < 8'd5 || q == 0 || q > MaxWriteDefault ||
              r.byte_count != 8'(q * 2) || 32'(r.data_size) != 5 + 32'(r.byte_count)) begin
            push_answer(StIllVal, fc, 8'd0, 16'd0, 16'd0, 1'b1);
          end else begin
            wr_err = span_mapped(1'b0, s, a, q) ? StNormal : StIllAddr;
            wr_base = a; wr_cnt = q; wr_left = q; wr_slot = s;
          end
        end else begin
          push_answer(StIllFunc, fc, 8'd0, 16'd0, 16'd0, 1'b1);
        end
      end
    end
  endfunction

  function automatic req_t mk(logic [1:0] md, logic [7:0] sa, logic [7:0] fc,
                              logic [15:0] ad, logic [15:0] q, logic [7:0] bc,
                              logic [7:0] ds, logic [15:0] w, logic tb);
    req_t r;
    r.mode = md; r.slave_address = sa; r.function_code = fc; r.reg_address = ad;
    r.quantity = q; r.byte_count = bc; r.data_size = ds; r.word_value = w;
    r.load_table = tb;
    return r;
  endfunction

  function automatic req_t noise_item();
    logic [95:0] raw;
    req_t r;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    return r;
  endfunction

  task automatic send(req_t r);
    int gap;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predict_answers(r);
    n_items++;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load(logic [7:0] sa, logic [15:0] ad, logic [15:0] w, logic tb);
    send(mk(ModeLoad, sa, 8'($urandom), ad, 16'($urandom), 8'($urandom), 8'($urandom), w, tb));
  endtask

  task automatic header(logic [7:0] sa, logic [7:0] fc, logic [15:0] ad, logic [15:0] q,
                        logic [7:0] bc, logic [7:0] ds);
    send(mk(ModeHeader, sa, fc, ad, q, bc, ds, 16'($urandom), 1'($urandom)));
  endtask

  task automatic payload(logic [15:0] w);
    send(mk(ModePayload, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
            8'($urandom), 8'($urandom), w, 1'($urandom)));
  endtask

  task automatic multi_write(logic [7:0] sa, logic [15:0] ad, int unsigned q, int unsigned sent);
    header(sa, FcWriteMulti, ad, 16'(q), 8'(q * 2), 8'(5 + q * 2));
    for (int unsigned i = 0; i < sent; i++) payload(16'($urandom));
  endtask

  task automatic set_slots(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2, logic [7:0] s3);
    logic [7:0] v[RegSlots];
    v = '{s0, s1, s2, s3};
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    for (int k = 0; k < RegSlots; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(k);
      cfg_data_i <= v[k];
      slave_of_slot[k] = v[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    set_slots(8'd1, 8'd247, 8'd0, 8'd42);
    load(8'd1, 16'd0, 16'h0000, 1'b0);
    load(8'd1, 16'd1, 16'hffff, 1'b0);
    load(8'd1, 16'd2, 16'h1234, 1'b0);
    load(8'd247, 16'd1023, 16'habcd, 1'b1);
    load(8'd42, 16'hffff, 16'h5555, 1'b1);
    header(8'd0, FcReadHolding, 16'd0, 16'd3, 8'd0, 8'd4);
    header(8'd255, FcReadHolding, 16'd1, 16'd2, 8'd0, 8'd4);
    header(8'd247, FcReadInput, 16'd1023, 16'd1, 8'd0, 8'd4);
    header(8'd247, FcReadInput, 16'd1023, 16'd2, 8'd0, 8'd4);
    header(8'd1, FcReadHolding, 16'd0, 16'd0, 8'd0, 8'd4);
    header(8'd1, FcReadHolding, 16'd0, 16'd126, 8'd0, 8'd4);
    header(8'd1, FcReadHolding, 16'd0, 16'd1, 8'd0, 8'd5);
    header(8'd1, FcWriteSingle, 16'd2, 16'hbeef, 8'd0, 8'd4);
    header(8'd1, FcWriteSingle, 16'd900, 16'd7, 8'd0, 8'd4);
    header(8'd1, FcWriteSingle, 16'd2, 16'd7, 8'd0, 8'd3);
    multi_write(8'd1, 16'd0, 2, 2);
    header(8'd1, FcWriteMulti, 16'd0, 16'd2, 8'd5, 8'd10);
    payload(16'h7777);
    multi_write(8'd1, 16'd1, 3, 1);
    header(8'd1, FcReadHolding, 16'd0, 16'd3, 8'd0, 8'd4);
    send(mk(2'd3, 8'd1, FcReadHolding, 16'd0, 16'd1, 8'd0, 8'd4, 16'd0, 1'b0));
    header(8'd100, FcReadHolding, 16'd0, 16'd1, 8'd0, 8'd4);
    header(8'd1, 8'd0, 16'd0, 16'd1, 8'd0, 8'd4);
    header(8'd1, 8'd255, 16'd0, 16'd1, 8'd0, 8'd4);
  endtask

  task automatic test_full_length();
    for (int unsigned i = 0; i < 125; i++) load(8'd247, 16'(200 + i), 16'($urandom), 1'b0);
    header(8'd247, FcReadHolding, 16'd200, 16'd125, 8'd0, 8'd4);
    multi_write(8'd247, 16'd201, 123, 123);
    header(8'd247, FcReadHolding, 16'd200, 16'd125, 8'd0, 8'd4);
    multi_write(8'd247, 16'd0, 123, 123);
  endtask

  function automatic logic [7:0] pick_slave();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return slave_of_slot[$urandom_range(0, RegSlots - 1)];
  endfunction

  function automatic logic [15:0] pick_addr();
    if ($urandom_range(0, 5) == 0) return 16'($urandom_range(NWords - 24, NWords - 1));
    return 16'($urandom_range(0, 40));
  endfunction

  task automatic test_random(int unsigned count);
    int unsigned sent_before, kind, q;
    sent_before = n_items;
    while (n_items - sent_before < count) begin
      if ($urandom_range(0, 39) == 0) burst = ~burst;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        load(pick_slave(), pick_addr(), 16'($urandom), 1'($urandom));
      end else if (kind < 50) begin
        q = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 125) : $urandom_range(1, 8);
        header(pick_slave(), $urandom_range(0, 1) ? FcReadInput : FcReadHolding,
               pick_addr(), 16'(q), 8'($urandom), $urandom_range(0, 9) ? 8'd4 : 8'($urandom));
      end else if (kind < 62) begin
        header(pick_slave(), FcWriteSingle, pick_addr(), 16'($urandom), 8'($urandom),
               $urandom_range(0, 9) ? 8'd4 : 8'($urandom));
      end else if (kind < 80) begin
        q = $urandom_range(1, 6);
        multi_write(pick_slave(), pick_addr(), q, $urandom_range(0, 7) ? q : $urandom_range(0, q));
      end else if (kind < 85) begin
        payload(16'($urandom));
      end else begin
        send(noise_item());
      end
    end
    burst = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      n_answers++;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, rsp_o);
        n_fail++;
      end else begin
        rsp_t e;
        e = answers_due.pop_front();
        if (rsp_o.status !== e.status || rsp_o.echo_function !== e.echo_function ||
            rsp_o.resp_byte_count !== e.resp_byte_count || rsp_o.word_first !== e.word_first ||
            rsp_o.word_second !== e.word_second || rsp_o.last !== e.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, e, rsp_o);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || rsp_valid_o || cfg_we_i) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    burst = 1'b0;
    wr_left = 0; wr_base = 0; wr_cnt = 0; wr_slot = 0; wr_err = StNormal;
    slave_of_slot = '{default: 8'd0};
    n_items = 0; n_answers = 0; n_fail = 0; idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    test_directed();
    test_full_length();
    set_slots(8'd5, 8'd247, 8'd1, 8'd200);
    test_random(20);
    set_slots(8'd0, 8'd9, 8'd247, 8'd1);
    test_random(20);
    set_slots(8'd247, 8'd0, 8'd0, 8'd0);
    test_random(20);
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Sent %0d items over four slot settings; checked %0d result transfers.",
             n_items, n_answers);
    $display("Covered reads, single and multiple writes, loads, exceptions and stray payloads.");
    if (n_fail == 0 && answers_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
